// File: rtl/core/psbc_pkg.sv
// Shared constants for the Polybius-square byte codec.
`timescale 1ns / 1ps
`default_nettype none
package psbc_pkg;

    localparam int RES_MAX = 4;          // most result bytes one input byte can cause

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_ONE   = 8'd49;

    localparam logic [7:0] LO_FIRST = 8'd33;   // first byte of the left block
    localparam logic [7:0] LO_LAST  = 8'd122;
    localparam logic [7:0] HI_FIRST = 8'd192;  // first byte of the right block
    localparam logic [7:0] HI_LAST  = 8'd254;
    localparam logic [7:0] BYTE_TOP = 8'd255;

    localparam logic       MODE_ENC = 1'b0;
    localparam logic       MODE_DEC = 1'b1;

endpackage
`default_nettype wire

// File: rtl/core/polybius_square_byte_codec_top.sv
// Top level of the Polybius-square byte codec: classify, encode/decode, result serializer.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel   Signals                                   Direction  Notes
//  -------   ---------------------------------------   ---------  ----------------------------
//  input     in_valid, in_ready, in_byte               sink       one byte per transfer
//  output    out_valid, out_ready, out_byte, last,     source     one result byte per transfer
//            bad_token
//  config    mode_we, mode_wdata                       sink       0 encode, 1 decode
//
//  An accepted byte is turned into its whole result set (zero to four bytes) in the
//  cycle of its transfer and lands in a four-entry result shift register.  The register
//  drains one byte per cycle while out_ready is high; the next byte is taken in the cycle
//  the last result leaves, or at once when the register is empty.
//  Reset clears mode (encode), the token state and the result count.
//  A stalled output holds the result register and, once it is non-empty, in_ready.
//
module polybius_square_byte_codec_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            last,
    output logic            bad_token,
    input  wire logic       mode_we,
    input  wire logic       mode_wdata
);
    import psbc_pkg::*;

    // Configuration and decode token state
    logic       mode_reg;
    logic [1:0] tok_len_reg, tok_len_next;
    logic [3:0] row_reg, row_next;
    logic [6:0] col_reg, col_next;

    // Result shift register: entry 0 is the byte on the output
    logic [7:0] bytes_reg [RES_MAX];
    logic [2:0] cnt_reg;
    logic       bad_reg;

    // Result set of the byte being transferred
    logic [7:0] res_bytes [RES_MAX];
    logic [2:0] res_cnt;
    logic       res_bad;

    logic accept;
    logic take;

    // Encode arithmetic: divide by 10 and by 7 through reciprocal multiplies
    logic [7:0]  idx_lo, idx_hi;
    logic [14:0] prod_lo;
    logic [11:0] prod_hi;
    logic [3:0]  rowq_lo, rowq_hi;
    logic [6:0]  rem_lo;
    logic [5:0]  rem_hi;
    logic        in_lo, in_hi;

    // Decode arithmetic
    logic       is_digit;
    logic [3:0] dig;
    logic [6:0] col_acc;
    logic [7:0] dec_lo, dec_hi;
    logic       tok_ok, tok_top;

    assign out_valid = (cnt_reg != 3'd0);
    assign take      = out_valid && out_ready;
    // Take the next byte when the register is empty or its final byte leaves now
    assign in_ready  = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && out_ready);
    assign accept    = in_valid && in_ready;

    assign out_byte  = bytes_reg[0];
    assign last      = (cnt_reg == 3'd1);
    assign bad_token = bad_reg;

    always_comb
    begin
        in_lo   = (in_byte >= LO_FIRST) && (in_byte <= LO_LAST);
        in_hi   = (in_byte >= HI_FIRST) && (in_byte <= HI_LAST);
        idx_lo  = in_byte - LO_FIRST;
        idx_hi  = in_byte - HI_FIRST;
        // x*205 >> 11 equals x/10 for x below 1029
        prod_lo = 15'(idx_lo[6:0]) * 15'd205;
        rowq_lo = prod_lo[14:11];
        rem_lo  = idx_lo[6:0] - 7'(7'(rowq_lo) * 7'd10);
        // x*37 >> 8 equals x/7 for x up to 62
        prod_hi = 12'(idx_hi[5:0]) * 12'd37;
        rowq_hi = prod_hi[11:8];
        rem_hi  = idx_hi[5:0] - 6'(6'(rowq_hi) * 6'd7);

        is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
        dig      = is_digit ? in_byte[3:0] : 4'd0;
        col_acc  = 7'(7'(col_reg * 7'd10) + 7'(dig));

        tok_top = (tok_len_reg == 2'd3) && (row_reg == 4'd9) && (col_reg == 7'd18);
        tok_ok  = (tok_len_reg >= 2'd2) && (row_reg >= 4'd1) && (row_reg <= 4'd9)
                  && (col_reg >= 7'd1) && (col_reg <= 7'd17);
        dec_lo  = LO_FIRST + 8'(8'(row_reg - 4'd1) * 8'd10) + 8'(col_reg - 7'd1);
        dec_hi  = HI_FIRST + 8'(8'(row_reg - 4'd1) * 8'd7) + 8'(col_reg) - 8'd11;
    end

    always_comb
    begin
        res_bytes[0] = CH_SPACE;
        res_bytes[1] = CH_SPACE;
        res_bytes[2] = CH_SPACE;
        res_bytes[3] = CH_SPACE;
        res_cnt      = 3'd0;
        res_bad      = 1'b0;
        tok_len_next = tok_len_reg;
        row_next     = row_reg;
        col_next     = col_reg;

        if (mode_reg == MODE_ENC) begin
            if (in_lo) begin
                res_bytes[0] = CH_ZERO + 8'(rowq_lo) + 8'd1;
                if (rem_lo == 7'd9) begin
                    // column ten spells as two digits
                    res_bytes[1] = CH_ONE;
                    res_bytes[2] = CH_ZERO;
                    res_cnt      = 3'd4;
                end else begin
                    res_bytes[1] = CH_ZERO + 8'(rem_lo) + 8'd1;
                    res_cnt      = 3'd3;
                end
            end else if (in_hi) begin
                res_bytes[0] = CH_ZERO + 8'(rowq_hi) + 8'd1;
                res_bytes[1] = CH_ONE;
                res_bytes[2] = CH_ZERO + 8'(rem_hi) + 8'd1;
                res_cnt      = 3'd4;
            end else if ((in_byte == BYTE_TOP) || (in_byte == CH_SPACE)) begin
                res_cnt = 3'd1;
            end else if (in_byte == CH_NL) begin
                res_bytes[0] = CH_NL;
                res_cnt      = 3'd1;
            end
        end else begin
            if (tok_len_reg == 2'd0) begin
                if ((in_byte == CH_SPACE) || (in_byte == CH_NL)) begin
                    res_bytes[0] = in_byte;
                    res_cnt      = 3'd1;
                end else begin
                    // open a token; a non-digit opens it already bad
                    tok_len_next = 2'd1;
                    row_next     = dig;
                    col_next     = 7'd0;
                end
            end else if (in_byte == CH_SPACE) begin
                // close the token and emit its byte or an error
                tok_len_next = 2'd0;
                row_next     = 4'd0;
                col_next     = 7'd0;
                res_cnt      = 3'd1;
                if (tok_top) begin
                    res_bytes[0] = BYTE_TOP;
                end else if (tok_ok) begin
                    res_bytes[0] = (col_reg <= 7'd10) ? dec_lo : dec_hi;
                end else begin
                    res_bytes[0] = 8'd0;
                    res_bad      = 1'b1;
                end
            end else if (!is_digit || (tok_len_reg == 2'd3)) begin
                row_next = 4'd0;
                if (tok_len_reg != 2'd3) begin
                    tok_len_next = tok_len_reg + 2'd1;
                end
            end else begin
                col_next     = (tok_len_reg == 2'd1) ? 7'(dig) : col_acc;
                tok_len_next = tok_len_reg + 2'd1;
            end
        end
    end

    // Control state: mode, token, result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= MODE_ENC;
            tok_len_reg <= 2'd0;
            row_reg     <= 4'd0;
            col_reg     <= 7'd0;
            cnt_reg     <= 3'd0;
            bad_reg     <= 1'b0;
        end else begin
            if (accept) begin
                tok_len_reg <= tok_len_next;
                row_reg     <= row_next;
                col_reg     <= col_next;
                cnt_reg     <= res_cnt;
                bad_reg     <= res_bad;
            end else if (take) begin
                cnt_reg <= cnt_reg - 3'd1;
                bad_reg <= 1'b0;
            end
            // A mode write also drops any open token
            if (mode_we) begin
                mode_reg    <= mode_wdata;
                tok_len_reg <= 2'd0;
                row_reg     <= 4'd0;
                col_reg     <= 7'd0;
            end
        end
    end

    // Result bytes: load on transfer in, advance on transfer out
    always_ff @(posedge clk)
    begin
        if (accept) begin
            for (int i = 0; i < RES_MAX; i++) begin
                bytes_reg[i] <= res_bytes[i];
            end
        end else if (take) begin
            for (int i = 0; i < RES_MAX - 1; i++) begin
                bytes_reg[i] <= bytes_reg[i + 1];
            end
        end
    end

endmodule
`default_nettype wire
